[rtl/sdpd_pkg.sv]
// Shared constants, codes, gain tables and control structs for the straight drive controller.
`default_nettype none

package sdpd_pkg;

  localparam int TIME_BITS_DEF    = 32;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int STRIKE_LIMIT_DEF = 3;

  localparam int WIDE_W    = 64;
  localparam int TGT_W     = 13;
  localparam int HEAD_W    = 15;
  localparam int CODE_W    = 2;
  localparam int TRAVEL_W  = 12;
  localparam int CEIL_W    = 8;
  localparam int LDRV_W    = 8;
  localparam int RDRV_W    = 9;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam int GAIN_W    = 11;
  localparam int MUL_STEPS = 12;
  localparam int OUT_W     = 24;

  // tick target = floor(travel * 102e13 / (32 * pi * 1e13)), taken as
  // (travel * ceil(2^62 * ratio)) >> 62; the rounding error stays below the
  // smallest fractional step of the exact quotient for any 12-bit travel
  localparam int TGT_FRAC = 62;
  localparam int RECIP_W  = 63;
  localparam int MACC_W   = TRAVEL_W + RECIP_W;
  localparam logic [127:0] TGT_NUM_K = 128'd1020000000000000;
  localparam logic [127:0] TGT_DEN_K = 128'd1005309649148734;
  localparam logic [RECIP_W-1:0] TGT_RECIP =
    RECIP_W'(((TGT_NUM_K << TGT_FRAC) + TGT_DEN_K - 128'd1) / TGT_DEN_K);

  localparam int HEAD_QUARTER = 5760;
  localparam int HEAD_HALF    = 11520;
  localparam int HEAD_FULL    = 23040;
  localparam int RIGHT_SCALE  = 282;
  localparam int SPEED_LIMIT  = 30;
  localparam int STALL_PERIOD = 250;
  localparam int IDLE_PERIOD  = 100;
  localparam int TRAVEL_MID   = 160;

  localparam logic [CFG_IDX_W-1:0] REG_HEADING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd2;

  localparam logic [STAT_W-1:0] ST_RUN   = 2'd0;
  localparam logic [STAT_W-1:0] ST_IDLE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABORT = 2'd2;
  localparam logic [STAT_W-1:0] ST_START = 2'd3;

  localparam logic [1:0] GS_MID   = 2'd0;
  localparam logic [1:0] GS_LONG  = 2'd1;
  localparam logic [1:0] GS_SHORT = 2'd2;

  typedef enum logic [1:0] {SEL_H, SEL_L, SEL_R} div_sel_t;

  typedef struct packed {
    logic     cap;
    logic     mul_step;
    logic     calc1;
    logic     calc2;
    logic     div_go;
    div_sel_t div_sel;
    logic     sum_a;
    logic     sum_b;
    logic     clamp;
    logic     scale;
    logic     finish;
  } sdpd_cmd_t;

  typedef struct packed {
    logic is_start;
    logic moving;
    logic dt_zero;
    logic mul_last;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sdpd_stat_t;

  function automatic logic [GAIN_W-1:0] enc_p(input logic [1:0] gs);
    case (gs)
      GS_MID:   enc_p = 11'd230;
      GS_LONG:  enc_p = 11'd384;
      default:  enc_p = 11'd333;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] enc_d(input logic [1:0] gs);
    case (gs)
      GS_MID:   enc_d = 11'd26;
      GS_LONG:  enc_d = 11'd1280;
      default:  enc_d = 11'd128;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] ang_p(input logic [1:0] gs);
    case (gs)
      GS_MID:   ang_p = 11'd512;
      default:  ang_p = 11'd0;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] ang_d(input logic [1:0] gs);
    case (gs)
      GS_MID:   ang_d = 11'd589;
      default:  ang_d = 11'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/sdpd_div.sv]
// Shared radix-2 restoring divider, signed numerator, unsigned divisor, truncating quotient.
`default_nettype none

module sdpd_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [sdpd_pkg::WIDE_W-1:0] num,
  input  wire logic        [sdpd_pkg::WIDE_W-1:0] den,
  output logic                                  busy,
  output logic                                  done,
  output logic signed      [sdpd_pkg::WIDE_W-1:0] quot
);
  import sdpd_pkg::*;

  localparam int CNT_W = $clog2(WIDE_W);

  logic [CNT_W-1:0]  cnt;
  logic [WIDE_W-1:0] q;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] den_r;
  logic              neg;
  logic [WIDE_W:0]   sh;
  logic [WIDE_W:0]   diff;

  assign sh   = {rem, q[WIDE_W-1]};
  assign diff = sh - {1'b0, den_r};
  assign quot = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        neg   <= num[WIDE_W-1];
        q     <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
        rem   <= '0;
        den_r <= den;
      end else if (busy) begin
        if (!diff[WIDE_W]) begin
          rem <= diff[WIDE_W-1:0];
          q   <= {q[WIDE_W-2:0], 1'b1};
        end else begin
          rem <= sh[WIDE_W-1:0];
          q   <= {q[WIDE_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sdpd_dp.sv]
// Datapath: configuration, move state, PD terms, clamps, stall and idle checks, result register.
`default_nettype none

module sdpd_dp #(
  parameter int TIME_BITS    = sdpd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS   = sdpd_pkg::COUNT_BITS_DEF,
  parameter int STRIKE_LIMIT = sdpd_pkg::STRIKE_LIMIT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [sdpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sdpd_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                               in_req,
  input  wire logic [TIME_BITS-1:0]               in_time,
  input  wire logic [sdpd_pkg::HEAD_W-1:0]        in_head,
  input  wire logic signed [COUNT_BITS-1:0]       in_left,
  input  wire logic signed [COUNT_BITS-1:0]       in_right_raw,
  input  wire sdpd_pkg::sdpd_cmd_t                cmd,
  output sdpd_pkg::sdpd_stat_t                    st,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [sdpd_pkg::LDRV_W-1:0]             out_left,
  output logic [sdpd_pkg::RDRV_W-1:0]             out_right,
  output logic [sdpd_pkg::STAT_W-1:0]             out_status
);
  import sdpd_pkg::*;

  localparam int EW    = ((COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W) + 2;
  localparam int DW    = EW + 1;
  localparam int SK_W  = $clog2(STRIKE_LIMIT + 1);
  localparam int MC_W  = $clog2(MUL_STEPS);
  localparam int EHW   = HEAD_W;
  localparam int DHW   = HEAD_W + 1;

  // configuration
  logic [CODE_W-1:0]   heading_code;
  logic [TRAVEL_W-1:0] travel_mm;
  logic [CEIL_W-1:0]   drive_ceiling;

  // move state
  logic                   moving;
  logic [TGT_W-1:0]       tick_target;
  logic [1:0]             gain_set;
  logic [CODE_W-1:0]      target_code;
  logic [TIME_BITS-1:0]   last_time, stall_window_start, idle_since;
  logic [HEAD_W-1:0]      last_heading;
  logic signed [EW-1:0]   last_left_error, last_right_error;
  logic signed [COUNT_BITS-1:0] stall_ref_left;
  logic signed [COUNT_BITS:0]   stall_ref_right;
  logic [SK_W-1:0]        stall_strikes;

  // captured item
  logic                   req;
  logic [TIME_BITS-1:0]   now;
  logic [HEAD_W-1:0]      head;
  logic signed [COUNT_BITS-1:0] left;
  logic signed [COUNT_BITS:0]   right;

  // working registers
  logic [MACC_W-1:0]      mul_acc;
  logic [MC_W-1:0]        mul_cnt;
  logic signed [EW-1:0]   el, er;
  logic signed [DW-1:0]   dl, dr;
  logic signed [EHW-1:0]  eh;
  logic signed [DHW-1:0]  dh;
  logic [TIME_BITS-1:0]   dt;
  logic                   dt_zero;
  logic signed [WIDE_W-1:0] pa, pl, pr, nh, nl, nr;
  logic signed [WIDE_W-1:0] qh, ql, qr;
  logic signed [WIDE_W-1:0] ang, l1, r1, lraw, rraw;
  logic [23:0]            lc, rc;
  logic [32:0]            rq24;
  div_sel_t               sel;

  // divider
  logic                     dv_busy, dv_done;
  logic signed [WIDE_W-1:0] dv_num, dv_quot;
  logic [WIDE_W-1:0]        dv_den;

  sdpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (dv_num),
    .den   (dv_den),
    .busy  (dv_busy),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  always_comb begin
    case (cmd.div_sel)
      SEL_H:   dv_num = nh;
      SEL_L:   dv_num = nl;
      SEL_R:   dv_num = nr;
      default: dv_num = nh;
    endcase
    dv_den = WIDE_W'(dt);
  end

  // combinational terms for the first calculation step
  logic signed [EW-1:0]   el_c, er_c;
  logic signed [16:0]     eh0;
  logic signed [EHW-1:0]  eh_c;
  logic signed [TGT_W:0]  tgt_s;

  assign tgt_s = $signed({1'b0, tick_target});
  assign el_c  = EW'(tgt_s) - EW'(left);
  assign er_c  = EW'(tgt_s) - EW'(right);
  assign eh0   = $signed(17'(target_code) * 17'(HEAD_QUARTER)) - $signed({2'b0, head});

  always_comb begin
    if (eh0 > 17'sd11520)
      eh_c = EHW'(eh0 - 17'sd23040);
    else if (eh0 <= -17'sd11520)
      eh_c = EHW'(eh0 + 17'sd23040);
    else
      eh_c = EHW'(eh0);
  end

  // products for the second step
  logic signed [GAIN_W+EHW:0]  pa_m;
  logic signed [GAIN_W+DHW:0]  nh_m;
  logic signed [GAIN_W+EW:0]   pl_m, pr_m;
  logic signed [GAIN_W+DW:0]   nl_m, nr_m;

  assign pa_m = $signed({1'b0, ang_p(gain_set)}) * eh;
  assign nh_m = $signed({1'b0, ang_d(gain_set)}) * dh;
  assign pl_m = $signed({1'b0, enc_p(gain_set)}) * el;
  assign pr_m = $signed({1'b0, enc_p(gain_set)}) * er;
  assign nl_m = $signed({1'b0, enc_d(gain_set)}) * dl;
  assign nr_m = $signed({1'b0, enc_d(gain_set)}) * dr;

  // clamp
  logic signed [WIDE_W-1:0] top;
  assign top = $signed(WIDE_W'({drive_ceiling, 16'b0}));

  // finish decisions
  logic                   fast, win, hit, abort, idle_out;
  logic signed [COUNT_BITS:0]   cl;
  logic signed [COUNT_BITS+1:0] cr;
  logic [SK_W-1:0]        strikes_new;
  logic [TIME_BITS-1:0]   idle_new;

  assign fast = (lc > 24'(SPEED_LIMIT << 16)) || (rq24 > 33'(SPEED_LIMIT) << 24);
  assign win  = (now - stall_window_start) >= TIME_BITS'(STALL_PERIOD);
  assign cl   = (COUNT_BITS+1)'(left) - (COUNT_BITS+1)'(stall_ref_left);
  assign cr   = (COUNT_BITS+2)'(right) - (COUNT_BITS+2)'(stall_ref_right);
  assign hit  = fast && (cl > -2) && (cl < 2) && (cr > -2) && (cr < 2);

  always_comb begin
    if (!hit)
      strikes_new = '0;
    else if (stall_strikes < SK_W'(STRIKE_LIMIT))
      strikes_new = stall_strikes + 1'b1;
    else
      strikes_new = stall_strikes;
  end

  assign abort    = win && (strikes_new >= SK_W'(STRIKE_LIMIT));
  assign idle_new = fast ? now : idle_since;
  assign idle_out = (now - idle_new) > TIME_BITS'(IDLE_PERIOD);

  assign st.is_start = !req;
  assign st.moving   = moving;
  assign st.dt_zero  = dt_zero;
  assign st.mul_last = (mul_cnt == MC_W'(MUL_STEPS));
  assign st.div_done = dv_done;
  assign st.div_busy = dv_busy;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_code  <= '0;
      travel_mm     <= TRAVEL_W'(TRAVEL_MID);
      drive_ceiling <= 8'd175;
      moving        <= 1'b0;
      out_valid     <= 1'b0;
      mul_cnt       <= '0;
      stall_strikes <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADING: heading_code  <= cfg_data[CODE_W-1:0];
          REG_TRAVEL:  travel_mm     <= cfg_data[TRAVEL_W-1:0];
          REG_CEILING: drive_ceiling <= cfg_data[CEIL_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready)
        out_valid <= 1'b0;

      if (cmd.cap) begin
        req     <= in_req;
        now     <= in_time;
        head    <= in_head;
        left    <= in_left;
        right   <= -(COUNT_BITS+1)'(in_right_raw);
        mul_acc <= '0;
        mul_cnt <= '0;
      end

      // shift-add product travel * reciprocal constant
      if (cmd.mul_step) begin
        if (travel_mm[mul_cnt])
          mul_acc <= mul_acc + (MACC_W'(TGT_RECIP) << mul_cnt);
        mul_cnt <= mul_cnt + 1'b1;
      end

      if (cmd.div_go)
        sel <= cmd.div_sel;

      if (dv_done) begin
        case (sel)
          SEL_H:   qh <= dv_quot;
          SEL_L:   ql <= dv_quot;
          SEL_R:   qr <= dv_quot;
          default: ;
        endcase
      end

      if (cmd.calc1) begin
        el      <= el_c;
        er      <= er_c;
        dl      <= DW'(el_c) - DW'(last_left_error);
        dr      <= DW'(er_c) - DW'(last_right_error);
        eh      <= eh_c;
        dh      <= $signed({1'b0, head}) - $signed({1'b0, last_heading});
        dt      <= now - last_time;
        dt_zero <= (now == last_time);
      end

      if (cmd.calc2) begin
        pa <= WIDE_W'(pa_m) <<< 2;
        nh <= WIDE_W'(nh_m) <<< 2;
        pl <= WIDE_W'(pl_m) <<< 8;
        pr <= WIDE_W'(pr_m) <<< 8;
        nl <= WIDE_W'(nl_m) <<< 8;
        nr <= WIDE_W'(nr_m) <<< 8;
        // no derivative on a zero time step
        qh <= '0;
        ql <= '0;
        qr <= '0;
      end

      if (cmd.sum_a) begin
        ang <= pa + qh;
        l1  <= pl + ql;
        r1  <= pr + qr;
      end

      if (cmd.sum_b) begin
        lraw <= l1 + ang;
        rraw <= r1 - ang;
      end

      if (cmd.clamp) begin
        lc <= (lraw < 0) ? 24'd0 : ((lraw > top) ? top[23:0] : lraw[23:0]);
        rc <= (rraw < 0) ? 24'd0 : ((rraw > top) ? top[23:0] : rraw[23:0]);
      end

      if (cmd.scale)
        rq24 <= 33'(rc) * 33'(RIGHT_SCALE);

      if (cmd.finish) begin
        out_valid  <= 1'b1;
        out_left   <= '0;
        out_right  <= '0;
        out_status <= ST_IDLE;
        if (!req) begin
          tick_target <= mul_acc[TGT_FRAC +: TGT_W];
          gain_set <= (travel_mm == TRAVEL_W'(TRAVEL_MID)) ? GS_MID :
                      ((travel_mm > TRAVEL_W'(TRAVEL_MID)) ? GS_LONG : GS_SHORT);
          target_code        <= heading_code;
          last_left_error    <= EW'(mul_acc[TGT_FRAC +: TGT_W]);
          last_right_error   <= EW'(mul_acc[TGT_FRAC +: TGT_W]);
          last_heading       <= head;
          last_time          <= now;
          stall_window_start <= now;
          idle_since         <= now;
          stall_ref_left     <= '0;
          stall_ref_right    <= '0;
          stall_strikes      <= '0;
          moving             <= 1'b1;
          out_status         <= ST_START;
        end else if (moving) begin
          if (win)
            stall_strikes <= strikes_new;
          if (abort) begin
            moving     <= 1'b0;
            out_status <= ST_ABORT;
          end else begin
            if (win) begin
              stall_ref_left     <= left;
              stall_ref_right    <= right;
              stall_window_start <= now;
            end
            idle_since <= idle_new;
            if (idle_out) begin
              moving <= 1'b0;
            end else begin
              out_left         <= lc[23:16];
              out_right        <= rq24[32:24];
              out_status       <= ST_RUN;
              last_time        <= now;
              last_heading     <= head;
              last_left_error  <= el;
              last_right_error <= er;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sdpd_ctrl.sv]
// Controller: sequences capture, target multiply, PD steps, shared divides and result hand-off.
`default_nettype none

module sdpd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sdpd_pkg::sdpd_stat_t st,
  output sdpd_pkg::sdpd_cmd_t       cmd
);
  import sdpd_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_MUL   = 14'b00000000000100,
    S_GOH   = 14'b00000000001000,
    S_CALC1 = 14'b00000000010000,
    S_CALC2 = 14'b00000000100000,
    S_DIVH  = 14'b00000001000000,
    S_DIVL  = 14'b00000010000000,
    S_DIVR  = 14'b00000100000000,
    S_SUMA  = 14'b00001000000000,
    S_SUMB  = 14'b00010000000000,
    S_CLAMP = 14'b00100000000000,
    S_SCALE = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.is_start)
          state_next = S_MUL;
        else if (!st.moving)
          state_next = S_DONE;
        else
          state_next = S_CALC1;
      end
      S_MUL: begin
        if (st.mul_last)
          state_next = S_DONE;
        else
          cmd.mul_step = 1'b1;
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2 = 1'b1;
        if (st.dt_zero)
          state_next = S_SUMA;
        else
          state_next = S_GOH;
      end
      S_GOH: begin
        // numerators are registered now
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_H;
        state_next  = S_DIVH;
      end
      S_DIVH: begin
        if (st.div_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = SEL_L;
          state_next  = S_DIVL;
        end
      end
      S_DIVL: begin
        if (st.div_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = SEL_R;
          state_next  = S_DIVR;
        end
      end
      S_DIVR: begin
        if (st.div_done)
          state_next = S_SUMA;
      end
      S_SUMA: begin
        cmd.sum_a  = 1'b1;
        state_next = S_SUMB;
      end
      S_SUMB: begin
        cmd.sum_b  = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register can take the new transfer
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= S_IDLE;
    else
      state <= state_next;
  end

  a_go_idle_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> !st.div_busy)
    else $error("divider started while busy");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> (state == S_DIVH || state == S_DIVL || state == S_DIVR))
    else $error("divide finished outside a divide wait");

  a_cap_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> state == S_DISP)
    else $error("capture did not advance to dispatch");

endmodule

`default_nettype wire

[rtl/straight_drive_pd_with_stall_abort.sv]
// Top level of the straight drive PD controller with stall abort.
//
//  channel  direction  handshake            payload
//  s_axis   in         tvalid/tready        tuser: req_type; tdata: time, heading, counts
//  m_axis   out        tvalid/tready        tdata: left_drive, right_drive, move_status
//  cfg      in         cfg_we               cfg_index, cfg_data
//
// A start item runs capture, dispatch, 12 shift-add steps for the reciprocal product that
// gives the tick target, a check that the steps are complete, and the result load.
// A tick while moving runs three divides by dt in turn on the shared radix-2 divider;
// a zero dt skips them. A tick while stopped goes from dispatch to the result load.
// The result register lets a finished result wait while the next item is accepted;
// a second result holds in the controller until taken.
// Reset is synchronous; no item is accepted while one is in work.
`default_nettype none

module straight_drive_pd_with_stall_abort #(
  parameter int TIME_BITS          = sdpd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS         = sdpd_pkg::COUNT_BITS_DEF,
  parameter int STALL_STRIKE_LIMIT = sdpd_pkg::STRIKE_LIMIT_DEF,
  parameter int IN_W = (((TIME_BITS + sdpd_pkg::HEAD_W + 2 * COUNT_BITS) + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // time_ms, heading, left_count, right_count_raw (from bit 0 up)
  input  wire logic [IN_W-1:0]                s_axis_tdata,
  // req_type
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // left_drive, right_drive, move_status (from bit 0 up)
  output logic [sdpd_pkg::OUT_W-1:0]          m_axis_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [sdpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sdpd_pkg::CFG_W-1:0]     cfg_data
);
  import sdpd_pkg::*;

  localparam int HEAD_LO  = TIME_BITS;
  localparam int LEFT_LO  = HEAD_LO + HEAD_W;
  localparam int RIGHT_LO = LEFT_LO + COUNT_BITS;

  sdpd_cmd_t  cmd;
  sdpd_stat_t st;

  logic [LDRV_W-1:0] out_left;
  logic [RDRV_W-1:0] out_right;
  logic [STAT_W-1:0] out_status;

  sdpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sdpd_dp #(
    .TIME_BITS    (TIME_BITS),
    .COUNT_BITS   (COUNT_BITS),
    .STRIKE_LIMIT (STALL_STRIKE_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req       (s_axis_tuser),
    .in_time      (s_axis_tdata[TIME_BITS-1:0]),
    .in_head      (s_axis_tdata[HEAD_LO +: HEAD_W]),
    .in_left      ($signed(s_axis_tdata[LEFT_LO +: COUNT_BITS])),
    .in_right_raw ($signed(s_axis_tdata[RIGHT_LO +: COUNT_BITS])),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_status   (out_status)
  );

  assign m_axis_tdata = OUT_W'({out_status, out_right, out_left});

endmodule

`default_nettype wire
